// ----- src/derq_pkg.sv -----
// ----------------------------------------------------------------------------
// derq_pkg: shared types, constants and helpers for the ring deque
// Sizes, operation and status codes, controller/datapath interface structs
// and the pointer stepping functions.
// ----------------------------------------------------------------------------
package derq_pkg;

  // Built storage and field widths
  localparam int DEPTH     = 64;
  localparam int WORD_W    = 32;
  localparam int MODE_W    = 3;
  localparam int IDX_W     = 6;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 7;
  localparam int COUNT_W   = 7;
  localparam int CAP_RESET = 64;

  // Derived widths
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CNTX_W  = CNT_W + 1;
  localparam int MOD_W   = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;
  localparam int MSTEP_W = $clog2(MOD_W + 1);

  // Register port
  localparam int APB_W  = 32;
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

  // Operation codes carried by the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_R = 3'd0,
    MODE_PUSH_L = 3'd1,
    MODE_POP_R  = 3'd2,
    MODE_POP_L  = 3'd3,
    MODE_RD_L   = 3'd4,
    MODE_RD_R   = 3'd5
  } mode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_t;

  // Operand choice for the remainder unit
  typedef enum logic [1:0] {
    MS_FRONT_IDX = 2'd0,
    MS_BACK      = 2'd1,
    MS_IDX       = 2'd2
  } msel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  latch;      // capture the accepted request
    logic  exec;       // decode and apply push/pop updates
    logic  mod_start;  // launch the remainder unit
    msel_t mod_sel;
    logic  save_b;     // keep first remainder of a right-end read
    logic  rd_issue;   // read the cell found for an indexed read
    logic  out_load;   // move the result into the output register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ok;
    logic is_rdl;
    logic is_rdr;
    logic mod_done;
    logic out_free;
  } dp_stat_t;

  // Capacity clamped to 1..DEPTH
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    if (c == '0) return CNT_W'(1);
    if (int'(c) > DEPTH) return CNT_W'(DEPTH);
    return CNT_W'(c);
  endfunction

  // Step right, wrapping past cap-1 to zero
  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(p) + CNT_W'(1);
    return (nx >= cap) ? '0 : PTR_W'(nx);
  endfunction

  // Step left, wrapping from zero (or beyond cap) to cap-1
  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
    if (p == '0 || CNT_W'(p) > cap) return PTR_W'(cap - CNT_W'(1));
    return p - PTR_W'(1);
  endfunction

endpackage

// ----- src/double_ended_ring_queue_top.sv -----
// ----------------------------------------------------------------------------
// double_ended_ring_queue_top: ring-buffer deque of 32-bit words
// Push/pop at either end and indexed reads, with a programmable capacity.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_*: mode, value, index; taken when in_valid is high and
//   in_stall is low. Every request yields exactly one result on out_*: data,
//   status (ok, full, empty/out of range) and the occupancy afterwards.
//   Pushes, pops and refused requests go from acceptance through decode to
//   out_valid; a read from the left adds one pass and a read from the right
//   two passes of the remainder unit, which wraps the index to the capacity.
//   The block works on one request at a time, so the next request is taken
//   only once the previous result has moved into the output register.
//   The result sits in an output register, so a new request is taken while
//   it waits; if out_stall holds, the next result waits inside the block and
//   in_stall stays high until the output register frees.
//   Reset empties the queue (pointers and occupancy to zero) and sets the
//   capacity to 64; cell contents are not cleared. Capacity lives at byte
//   address 0 of the register port; the user must write it only while idle,
//   as the block does not enforce this.
// ----------------------------------------------------------------------------
module double_ended_ring_queue_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [derq_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [derq_pkg::WORD_W-1:0]  in_value,
  input  logic [derq_pkg::IDX_W-1:0]          in_index,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [derq_pkg::WORD_W-1:0]  out_data,
  output logic [derq_pkg::STAT_W-1:0]         out_status,
  output logic [derq_pkg::COUNT_W-1:0]        out_count,
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [derq_pkg::ADDR_W-1:0]         paddr,
  input  logic [derq_pkg::APB_W-1:0]          pwdata,
  output logic [derq_pkg::APB_W-1:0]          prdata,
  output logic                                pready
);
  import derq_pkg::*;

  ctl_cmd_t         cmd;
  dp_stat_t         st;
  logic             cap_we;
  logic [CAP_W-1:0] cap_rdata;
  logic [ADDR_W-3:0] reg_idx;

  // Register decode
  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cap_we  = psel && penable && pwrite && (reg_idx == REG_CAPACITY);
  assign prdata  = (reg_idx == REG_CAPACITY) ? APB_W'(cap_rdata) : '0;

  derq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  derq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .in_index   (in_index),
    .cap_we     (cap_we),
    .cap_wdata  (pwdata[CAP_W-1:0]),
    .cap_rdata  (cap_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .out_status (out_status),
    .out_count  (out_count)
  );

endmodule

// ----- src/derq_mod.sv -----
// ----------------------------------------------------------------------------
// derq_mod: iterative remainder unit
// Restoring remainder, one numerator bit per cycle; done pulses in the cycle
// after the last step with the remainder held until the next start.
// ----------------------------------------------------------------------------
module derq_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [derq_pkg::MOD_W-1:0]  num,
  input  logic [derq_pkg::CNT_W-1:0]  den,
  output logic                        done,
  output logic [derq_pkg::PTR_W-1:0]  rem
);
  import derq_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [MSTEP_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0]   num_r, num_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNTX_W-1:0]  trial;

  // One shift-and-subtract step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, num_r[MOD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = MSTEP_W'(MOD_W);
      num_nxt  = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= CNTX_W'(den)) begin
        rem_nxt = CNT_W'(trial - CNTX_W'(den));
      end else begin
        rem_nxt = CNT_W'(trial);
      end
      num_nxt = num_r << 1;
      cnt_nxt = cnt_r - MSTEP_W'(1);
      if (cnt_r == MSTEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and partial remainder
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = PTR_W'(rem_r);

endmodule

// ----- src/derq_ctrl.sv -----
// ----------------------------------------------------------------------------
// derq_ctrl: deque sequencer
// Takes one request at a time, runs decode, the remainder passes for indexed
// reads, and hands the result to the output register.
// ----------------------------------------------------------------------------
module derq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  derq_pkg::dp_stat_t  st,
  output derq_pkg::ctl_cmd_t  cmd
);
  import derq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_MOD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;  // second remainder pass of a right-end read

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    cmd         = '0;
    cmd.mod_sel = MS_FRONT_IDX;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.exec  = 1'b1;
        phase_nxt = 1'b0;
        if (st.ok && st.is_rdl) begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MS_FRONT_IDX;
          state_nxt     = S_MOD;
        end else if (st.ok && st.is_rdr) begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MS_BACK;
          state_nxt     = S_MOD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MOD: begin
        if (st.mod_done) begin
          if (st.is_rdr && !phase_r) begin
            cmd.save_b    = 1'b1;
            cmd.mod_start = 1'b1;
            cmd.mod_sel   = MS_IDX;
            phase_nxt     = 1'b1;
          end else begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- src/derq_dp.sv -----
// ----------------------------------------------------------------------------
// derq_dp: deque datapath
// Cell memory, end pointers, occupancy, capacity register, status decode,
// index wrap through the remainder unit and the output register.
// ----------------------------------------------------------------------------
module derq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  derq_pkg::ctl_cmd_t                  cmd,
  output derq_pkg::dp_stat_t                  st,
  input  logic [derq_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [derq_pkg::WORD_W-1:0]  in_value,
  input  logic [derq_pkg::IDX_W-1:0]          in_index,
  input  logic                                cap_we,
  input  logic [derq_pkg::CAP_W-1:0]          cap_wdata,
  output logic [derq_pkg::CAP_W-1:0]          cap_rdata,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [derq_pkg::WORD_W-1:0]  out_data,
  output logic [derq_pkg::STAT_W-1:0]         out_status,
  output logic [derq_pkg::COUNT_W-1:0]        out_count
);
  import derq_pkg::*;

  // Request registers
  logic [MODE_W-1:0] mode_r;
  logic [WORD_W-1:0] value_r;
  logic [IDX_W-1:0]  index_r;

  // Queue state
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [PTR_W-1:0] front_r, front_nxt;
  logic [PTR_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [WORD_W-1:0] cells [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // Per-request results
  stat_t            status_r, status_nxt;
  logic             from_mem_r, from_mem_nxt;
  logic [PTR_W-1:0] b_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r;
  logic [STAT_W-1:0] out_status_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [CNT_W-1:0]  cap;
  stat_t             stat;
  logic              ok;
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [PTR_W-1:0]  front_dn, back_dn;
  logic [MOD_W-1:0]  mod_num;
  logic              mod_done;
  logic [PTR_W-1:0]  mod_rem;
  logic [CNTX_W-1:0] t_sum;
  logic [PTR_W-1:0]  right_addr;
  logic              out_free;

  assign cap      = eff_cap(cap_r);
  assign front_dn = step_down(front_r, cap);
  assign back_dn  = step_down(back_r, cap);

  // Status decode for the held request
  always_comb begin
    case (mode_t'(mode_r))
      MODE_PUSH_R, MODE_PUSH_L: stat = (occ_r >= cap) ? ST_FULL : ST_OK;
      MODE_POP_R, MODE_POP_L:   stat = (occ_r == '0) ? ST_EMPTY : ST_OK;
      MODE_RD_L, MODE_RD_R:     stat = (int'(index_r) >= int'(occ_r)) ? ST_EMPTY : ST_OK;
      default:                  stat = ST_EMPTY;
    endcase
  end

  assign ok = (stat == ST_OK);

  // Remainder unit operands
  always_comb begin
    case (cmd.mod_sel)
      MS_FRONT_IDX: mod_num = MOD_W'(front_r) + MOD_W'(index_r);
      MS_BACK:      mod_num = MOD_W'(back_r);
      MS_IDX:       mod_num = MOD_W'(index_r);
      default:      mod_num = '0;
    endcase
  end

  derq_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mod_start),
    .num   (mod_num),
    .den   (cap),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Right-end read: (back mod cap) + cap - 1 - (index mod cap), wrapped once
  always_comb begin
    t_sum = CNTX_W'(b_r) + CNTX_W'(cap) - CNTX_W'(1) - CNTX_W'(mod_rem);
    if (t_sum >= CNTX_W'(cap)) begin
      right_addr = PTR_W'(t_sum - CNTX_W'(cap));
    end else begin
      right_addr = PTR_W'(t_sum);
    end
  end

  // Push/pop updates and memory access
  always_comb begin
    front_nxt    = front_r;
    back_nxt     = back_r;
    occ_nxt      = occ_r;
    wr_en        = 1'b0;
    wr_addr      = back_r;
    rd_en        = 1'b0;
    rd_addr      = front_r;
    status_nxt   = status_r;
    from_mem_nxt = from_mem_r;
    if (cmd.exec) begin
      status_nxt   = stat;
      from_mem_nxt = 1'b0;
      if (ok) begin
        case (mode_t'(mode_r))
          MODE_PUSH_R: begin
            wr_en    = 1'b1;
            wr_addr  = back_r;
            back_nxt = step_up(back_r, cap);
            occ_nxt  = occ_r + CNT_W'(1);
          end
          MODE_PUSH_L: begin
            wr_en     = 1'b1;
            wr_addr   = front_dn;
            front_nxt = front_dn;
            occ_nxt   = occ_r + CNT_W'(1);
          end
          MODE_POP_R: begin
            rd_en        = 1'b1;
            rd_addr      = back_dn;
            back_nxt     = back_dn;
            occ_nxt      = occ_r - CNT_W'(1);
            from_mem_nxt = 1'b1;
          end
          MODE_POP_L: begin
            rd_en        = 1'b1;
            rd_addr      = front_r;
            front_nxt    = step_up(front_r, cap);
            occ_nxt      = occ_r - CNT_W'(1);
            from_mem_nxt = 1'b1;
          end
          MODE_RD_L, MODE_RD_R: begin
            from_mem_nxt = 1'b1;
          end
          default: begin
            from_mem_nxt = 1'b0;
          end
        endcase
      end
    end
    if (cmd.rd_issue) begin
      rd_en   = 1'b1;
      rd_addr = (mode_t'(mode_r) == MODE_RD_L) ? mod_rem : right_addr;
    end
  end

  // Capacity register
  assign cap_nxt   = cap_we ? cap_wdata : cap_r;
  assign cap_rdata = cap_r;

  // Output register handshake
  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_W'(CAP_RESET);
      front_r     <= '0;
      back_r      <= '0;
      occ_r       <= '0;
      status_r    <= ST_OK;
      from_mem_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      occ_r       <= occ_nxt;
      status_r    <= status_nxt;
      from_mem_r  <= from_mem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture and saved remainder
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r  <= in_mode;
      value_r <= in_value;
      index_r <= in_index;
    end
    if (cmd.save_b) begin
      b_r <= mod_rem;
    end
  end

  // Cell memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= value_r;
    end
    if (rd_en) begin
      rdata_r <= cells[rd_addr];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r   <= from_mem_r ? rdata_r : '0;
      out_status_r <= status_r;
      out_count_r  <= COUNT_W'(occ_r);
    end
  end

  assign st.ok       = ok;
  assign st.is_rdl   = (mode_t'(mode_r) == MODE_RD_L);
  assign st.is_rdr   = (mode_t'(mode_r) == MODE_RD_R);
  assign st.mod_done = mod_done;
  assign st.out_free = out_free;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule
